### rtl/core/liv_pkg.sv
// shared types and constants for the lexicon image validator
// no dependencies; used by liv_fnv, liv_parser and lexicon_image_validator

package liv_pkg;

    // image layout
    localparam int unsigned HEADER_BYTES = 20;
    localparam int unsigned POS_W        = 29;
    localparam int unsigned ENTRY_W      = 23;
    localparam int unsigned HASH_W       = 64;

    localparam logic [POS_W-1:0]   POS_MAX     = {POS_W{1'b1}};
    localparam logic [ENTRY_W-1:0] ENTRIES_MAX = {ENTRY_W{1'b1}};

    // fnv-1a 64 constants
    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF29CE484222325;

    // header signature bytes, in file order
    localparam logic [7:0] MAGIC [4] = '{8'h4F, 8'h57, 8'h4C, 8'h58};

    // configuration register indexes
    localparam logic [1:0] CFG_VERSION   = 2'd0;
    localparam logic [1:0] CFG_MAX_ENTRY = 2'd1;
    localparam logic [1:0] CFG_MAX_BYTES = 2'd2;

    // reset values of the configuration registers
    localparam logic [31:0]        VERSION_RST   = 32'd1;
    localparam logic [ENTRY_W-1:0] MAX_ENTRY_RST = 23'd4194304;
    localparam logic [POS_W-1:0]   MAX_BYTES_RST = 29'd268435456;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_SIZE       = 4'd1,
        ST_MAGIC      = 4'd2,
        ST_VERSION    = 4'd3,
        ST_HEADER     = 4'd4,
        ST_CHECKSUM   = 4'd5,
        ST_ENTRY_HEAD = 4'd6,
        ST_SYL_TRUNC  = 4'd7,
        ST_BAD_SYL    = 4'd8,
        ST_TEXT       = 4'd9,
        ST_TRAILING   = 4'd10
    } t_status;

    typedef enum logic [2:0] {
        PH_HEAD    = 3'd0,
        PH_SYLLEN  = 3'd1,
        PH_SYLBODY = 3'd2,
        PH_TEXT    = 3'd3,
        PH_TRAIL   = 3'd4
    } t_phase;

    typedef struct packed {
        logic [31:0]        expected_version;
        logic [ENTRY_W-1:0] max_entries;
        logic [POS_W-1:0]   max_file_bytes;
    } t_cfg;

    typedef struct packed {
        t_status            status;
        logic [ENTRY_W-1:0] entries_seen;
    } t_result;

endpackage

### rtl/core/liv_fnv.sv
// running fnv-1a 64 hash register over payload bytes
// depends on liv_pkg

module liv_fnv (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_payload,
    input  logic                       i_clear,
    input  logic [7:0]                 i_byte,
    output logic [liv_pkg::HASH_W-1:0] o_hash_next
);

    logic [liv_pkg::HASH_W-1:0] r_hash;
    logic [liv_pkg::HASH_W-1:0] x;
    logic [liv_pkg::HASH_W-1:0] n_hash;

    // xor in the byte, then multiply by the prime 2^40 + 0x1b3 as shifts and adds
    always_comb begin
        x = r_hash ^ {56'd0, i_byte};
        n_hash = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
        if (i_step && i_payload) begin
            o_hash_next = n_hash;
        end else begin
            o_hash_next = r_hash;
        end
    end

    // hash register, back to the basis after each image
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= liv_pkg::FNV_BASIS;
        end else if (i_step && i_clear) begin
            r_hash <= liv_pkg::FNV_BASIS;
        end else begin
            r_hash <= o_hash_next;
        end
    end

endmodule

### rtl/core/liv_parser.sv
// header checks, entry walk and final status of the lexicon image
// depends on liv_pkg; takes the next hash value from liv_fnv

module liv_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [7:0]                 i_byte,
    input  logic                       i_last,
    input  liv_pkg::t_cfg              i_cfg,
    input  logic [liv_pkg::HASH_W-1:0] i_hash_next,
    output logic                       o_payload,
    output liv_pkg::t_result           o_result
);

    logic [liv_pkg::POS_W-1:0]   r_pos,        n_pos;
    logic                        r_magic_ok,   n_magic_ok;
    logic [63:0]                 r_hdr,        n_hdr;
    logic [31:0]                 r_decl_count, n_decl_count;
    logic [63:0]                 r_decl_hash,  n_decl_hash;
    liv_pkg::t_phase             r_phase,      n_phase;
    logic [2:0]                  r_fidx,       n_fidx;
    logic [15:0]                 r_syl_left,   n_syl_left;
    logic [15:0]                 r_bytes_left, n_bytes_left;
    logic [15:0]                 r_text_len,   n_text_len;
    logic [liv_pkg::ENTRY_W-1:0] r_entries,    n_entries;
    liv_pkg::t_status            r_err,        n_err;

    logic no_err;

    assign o_payload = (r_pos >= liv_pkg::POS_W'(liv_pkg::HEADER_BYTES));
    assign no_err    = (r_err == liv_pkg::ST_OK);

    // next state for one byte
    always_comb begin
        n_pos        = (r_pos != liv_pkg::POS_MAX) ? r_pos + 1'b1 : r_pos;
        n_magic_ok   = r_magic_ok;
        n_hdr        = r_hdr;
        n_decl_count = r_decl_count;
        n_decl_hash  = r_decl_hash;
        n_phase      = r_phase;
        n_fidx       = r_fidx;
        n_syl_left   = r_syl_left;
        n_bytes_left = r_bytes_left;
        n_text_len   = r_text_len;
        n_entries    = r_entries;
        n_err        = r_err;

        if (!o_payload) begin
            // header bytes shift in from the top, little-endian
            n_hdr = {i_byte, r_hdr[63:8]};
            if (r_pos < liv_pkg::POS_W'(4) && i_byte != liv_pkg::MAGIC[r_pos[1:0]]) begin
                n_magic_ok = 1'b0;
            end
            if (r_pos == liv_pkg::POS_W'(7) && n_hdr[63:32] != i_cfg.expected_version
                && no_err) begin
                n_err = liv_pkg::ST_VERSION;
            end
            if (r_pos == liv_pkg::POS_W'(11)) begin
                n_decl_count = n_hdr[63:32];
                if (n_hdr[63:32] > {9'd0, i_cfg.max_entries} && no_err) begin
                    n_err = liv_pkg::ST_HEADER;
                end
            end
            if (r_pos == liv_pkg::POS_W'(19)) begin
                n_decl_hash = n_hdr;
                n_phase     = (r_decl_count == 32'd0) ? liv_pkg::PH_TRAIL : liv_pkg::PH_HEAD;
                n_fidx      = 3'd0;
            end
        end else if (no_err) begin
            // entry walk, stops at the first error
            unique case (r_phase)
                liv_pkg::PH_HEAD: begin
                    case (r_fidx)
                        3'd4:    n_syl_left = {8'd0, i_byte};
                        3'd5:    n_syl_left = {i_byte, r_syl_left[7:0]};
                        3'd6:    n_text_len = {8'd0, i_byte};
                        3'd7:    n_text_len = {i_byte, r_text_len[7:0]};
                        default: ;
                    endcase
                    if (r_fidx == 3'd7) begin
                        n_fidx = 3'd0;
                        if (n_syl_left == 16'd0 || n_text_len == 16'd0) begin
                            n_err = liv_pkg::ST_ENTRY_HEAD;
                        end else begin
                            n_phase = liv_pkg::PH_SYLLEN;
                        end
                    end else begin
                        n_fidx = r_fidx + 1'b1;
                    end
                end
                liv_pkg::PH_SYLLEN: begin
                    if (i_byte == 8'd0) begin
                        n_err = liv_pkg::ST_BAD_SYL;
                    end else begin
                        n_bytes_left = {8'd0, i_byte};
                        n_phase      = liv_pkg::PH_SYLBODY;
                    end
                end
                liv_pkg::PH_SYLBODY: begin
                    n_bytes_left = r_bytes_left - 1'b1;
                    if (n_bytes_left == 16'd0) begin
                        n_syl_left = r_syl_left - 1'b1;
                        if (n_syl_left == 16'd0) begin
                            n_bytes_left = r_text_len;
                            n_phase      = liv_pkg::PH_TEXT;
                        end else begin
                            n_phase = liv_pkg::PH_SYLLEN;
                        end
                    end
                end
                liv_pkg::PH_TEXT: begin
                    n_bytes_left = r_bytes_left - 1'b1;
                    if (n_bytes_left == 16'd0) begin
                        if (r_entries != liv_pkg::ENTRIES_MAX) begin
                            n_entries = r_entries + 1'b1;
                        end
                        n_phase = ({9'd0, n_entries} >= r_decl_count) ?
                                  liv_pkg::PH_TRAIL : liv_pkg::PH_HEAD;
                        n_fidx  = 3'd0;
                    end
                end
                default: begin
                    n_err = liv_pkg::ST_TRAILING;
                end
            endcase
        end
    end

    // final status in check order, from the state after this byte
    always_comb begin
        o_result.entries_seen = n_entries;
        if (n_pos < liv_pkg::POS_W'(liv_pkg::HEADER_BYTES) || n_pos > i_cfg.max_file_bytes
            || n_pos == liv_pkg::POS_MAX) begin
            o_result.status = liv_pkg::ST_SIZE;
        end else if (!n_magic_ok) begin
            o_result.status = liv_pkg::ST_MAGIC;
        end else if (n_err == liv_pkg::ST_VERSION || n_err == liv_pkg::ST_HEADER) begin
            o_result.status = n_err;
        end else if (i_hash_next != n_decl_hash) begin
            o_result.status = liv_pkg::ST_CHECKSUM;
        end else if (n_err != liv_pkg::ST_OK) begin
            o_result.status = n_err;
        end else begin
            case (n_phase)
                liv_pkg::PH_HEAD:    o_result.status = liv_pkg::ST_ENTRY_HEAD;
                liv_pkg::PH_SYLLEN:  o_result.status = liv_pkg::ST_SYL_TRUNC;
                liv_pkg::PH_SYLBODY: o_result.status = liv_pkg::ST_BAD_SYL;
                liv_pkg::PH_TEXT:    o_result.status = liv_pkg::ST_TEXT;
                default:             o_result.status = liv_pkg::ST_OK;
            endcase
        end
    end

    // parser state, cleared after the final byte of an image
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_pos        <= '0;
            r_magic_ok   <= 1'b1;
            r_hdr        <= '0;
            r_decl_count <= '0;
            r_decl_hash  <= '0;
            r_phase      <= liv_pkg::PH_HEAD;
            r_fidx       <= '0;
            r_syl_left   <= '0;
            r_bytes_left <= '0;
            r_text_len   <= '0;
            r_entries    <= '0;
            r_err        <= liv_pkg::ST_OK;
        end else if (i_step) begin
            r_pos        <= n_pos;
            r_magic_ok   <= n_magic_ok;
            r_hdr        <= n_hdr;
            r_decl_count <= n_decl_count;
            r_decl_hash  <= n_decl_hash;
            r_phase      <= n_phase;
            r_fidx       <= n_fidx;
            r_syl_left   <= n_syl_left;
            r_bytes_left <= n_bytes_left;
            r_text_len   <= n_text_len;
            r_entries    <= n_entries;
            r_err        <= n_err;
        end
    end

endmodule

### rtl/core/lexicon_image_validator.sv
// Lexicon image validator, top level.
// Image bytes arrive on the s_axis channel, one word per byte, with s_axis_tlast
// on the final byte of an image. Each byte is held in an input register, then
// the header checks, the fnv-1a 64 hash step and the entry walk update the
// state together, in the same cycle.
// One result word leaves on m_axis per image, only for the final byte: status,
// entries parsed and payload hash. Bytes without tlast give no result.
// A result is written to the output register as its final byte leaves the input register.
// Throughput: one byte per cycle unless a final byte is held, as the hash loop has one register.
// The block keeps taking bytes while a result waits in the output register;
// only a further final byte is held in the input register until the receiver
// takes the waiting result.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 expected version, 1 max entries, 2 max image bytes); write only when idle.
// Reset (i_rst_n low, synchronous) empties both registers, restores the
// configuration defaults and starts a fresh image; after each final byte the
// parser returns to that same start state, keeping the configuration.
// depends on liv_pkg, liv_fnv, liv_parser

module lexicon_image_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input image bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [3:0] status, [26:4] entries_seen,
                                        // [90:27] payload_hash, [95:91] zero
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic                       r_in_valid;
    logic [7:0]                 r_in_byte;
    logic                       r_in_last;
    logic                       r_out_valid;
    logic [95:0]                r_out_data;
    liv_pkg::t_cfg              r_cfg;
    logic                       step;
    logic                       out_free;
    logic                       payload;
    logic [liv_pkg::HASH_W-1:0] hash_next;
    liv_pkg::t_result           result;

    // a final byte moves on only when the output register can take its result
    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && (!r_in_last || out_free);
    assign s_axis_tready = !r_in_valid || step;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_version <= liv_pkg::VERSION_RST;
            r_cfg.max_entries      <= liv_pkg::MAX_ENTRY_RST;
            r_cfg.max_file_bytes   <= liv_pkg::MAX_BYTES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                liv_pkg::CFG_VERSION:   r_cfg.expected_version <= i_cfg_data;
                liv_pkg::CFG_MAX_ENTRY: r_cfg.max_entries <= i_cfg_data[liv_pkg::ENTRY_W-1:0];
                liv_pkg::CFG_MAX_BYTES: r_cfg.max_file_bytes <= i_cfg_data[liv_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    liv_fnv u_fnv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_payload   (payload),
        .i_clear     (r_in_last),
        .i_byte      (r_in_byte),
        .o_hash_next (hash_next)
    );

    liv_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .i_cfg       (r_cfg),
        .i_hash_next (hash_next),
        .o_payload   (payload),
        .o_result    (result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (step && r_in_last) begin
            r_out_data <= {5'd0, hash_next, result.entries_seen, result.status};
        end
    end

endmodule
